[hdl/mts_pkg.sv]
// shared types and codes for the model transform stack
// no dependencies
`default_nettype none

package mts_pkg;

    // input function codes
    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_ELEM  = 1'b1;

    // element position that completes a transform
    localparam logic [3:0] LAST_ELEM = 4'd15;

    typedef struct packed {
        logic               func;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic [31:0]        transform_id;
    } item_t;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_value;
        logic               reused;
        logic               overflow;
        logic               last_out;
    } result_t;

    // control word travelling with one multiply-accumulate step
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [3:0] index;
    } mac_ctrl_t;

endpackage

`default_nettype wire

[hdl/mts_ram.sv]
// generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/mts_mac.sv]
// shared multiply-accumulate unit with scale and saturation
// depends on mts_pkg
`default_nettype none

module mts_mac
    import mts_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mac_ctrl_t          ctrl,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    res_valid,
    output logic [3:0]              res_index,
    output logic signed [31:0]      res_value
);

    localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    mac_ctrl_t          ctrl_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic signed [63:0] sum;
    logic signed [63:0] shifted;
    logic [32:0]        high_bits;

    assign prod_next = a * b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // wraps modulo 2^64
    always_comb
    begin
        sum       = (ctrl_reg.first ? 64'sd0 : acc_reg) + prod_reg;
        acc_next  = ctrl_reg.valid ? sum : acc_reg;
        shifted   = sum >>> FRAC_BITS;
        high_bits = shifted[63:31];
        if (high_bits == '0 || high_bits == '1)
        begin
            res_value = shifted[31:0];
        end
        else
        begin
            res_value = shifted[63] ? SAT_MIN : SAT_MAX;
        end
    end

    assign res_valid = ctrl_reg.valid && ctrl_reg.last;
    assign res_index = ctrl_reg.index;

endmodule

`default_nettype wire

[hdl/model_transform_stack_4x4.sv]
// top level: stack of tagged 4x4 fixed-point transforms
// depends on mts_pkg, mts_ram, mts_mac
// begin items and elements 0..14 are accepted in idle, busy stays low
// element 15: id search over up to stack_count entries, one id read per cycle,
//   then either a copy (one result per cycle) or a product of 64
//   multiply-accumulates on the single shared multiplier (each result sums four of them)
// a full stack gives its overflow result the cycle after the item, busy stays low
// reset: stack_count is 1; entry 0 (identity, id 0) comes from logic, no clearing pass
`default_nettype none

module model_transform_stack_4x4
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    output logic       busy,
    output logic       valid,
    output result_t    result
);

    localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int MADDR_W = PTR_W + 4;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [31:0]      ONE_FIX = 32'd1 << FRAC_BITS;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_COPY   = 2'd2;
    localparam logic [1:0] ST_MULT   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [31:0]        tid_reg, tid_next;
    logic [PTR_W-1:0]   sptr_reg, sptr_next;
    logic [PTR_W-1:0]   hit_reg, hit_next;
    logic               live_reg, live_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [PTR_W-1:0]   cmp_addr_reg, cmp_addr_next;
    logic [5:0]         step_reg, step_next;
    logic               cp_valid_reg, cp_valid_next;
    logic [3:0]         cp_elem_reg, cp_elem_next;
    logic               m_zero_reg;
    logic [3:0]         m_elem_reg;
    logic signed [31:0] inc_q_reg;
    mac_ctrl_t          mac_ctrl_reg, mac_ctrl_next;
    logic               valid_reg, valid_next;
    result_t            result_reg, result_next;

    // matrix being delivered, column-major
    logic signed [31:0] inc_mat [16];

    logic               accept;
    logic [PTR_W-1:0]   dst_ptr;
    logic [PTR_W-1:0]   top_ptr;

    logic               m_we;
    logic [MADDR_W-1:0] m_waddr;
    logic [31:0]        m_wdata;
    logic [MADDR_W-1:0] m_raddr;
    logic [31:0]        m_rdata;
    logic [31:0]        m_rdata_eff;

    logic               id_we;
    logic [31:0]        id_rdata;
    logic [31:0]        id_eff;

    logic               mac_res_valid;
    logic [3:0]         mac_res_index;
    logic signed [31:0] mac_res_value;

    assign accept  = start && !busy;
    assign dst_ptr = count_reg[PTR_W-1:0];
    assign top_ptr = PTR_W'(dst_ptr - 1'b1);

    // copy reads the hit entry in order; product reads top[col*4+k]
    always_comb
    begin
        if (state_reg == ST_COPY)
        begin
            m_raddr = {hit_reg, step_reg[3:0]};
        end
        else
        begin
            m_raddr = {top_ptr, step_reg[5:4], step_reg[1:0]};
        end
    end

    // entry 0 is never written: identity is supplied here
    always_comb
    begin
        if (m_zero_reg)
        begin
            m_rdata_eff = (m_elem_reg[3:2] == m_elem_reg[1:0]) ? ONE_FIX : 32'd0;
        end
        else
        begin
            m_rdata_eff = m_rdata;
        end
    end

    // id of entry 0 is always zero
    assign id_eff = (cmp_addr_reg == '0) ? 32'd0 : id_rdata;

    // one multiply-accumulate step per cycle while the product runs
    always_comb
    begin
        mac_ctrl_next.valid = (state_reg == ST_MULT) && live_reg;
        mac_ctrl_next.first = (step_reg[1:0] == 2'd0);
        mac_ctrl_next.last  = (step_reg[1:0] == 2'd3);
        mac_ctrl_next.index = step_reg[5:2];
    end

    mts_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH * 16)
    ) u_matrix_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    mts_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (dst_ptr),
        .wdata (tid_reg),
        .raddr (sptr_reg),
        .rdata (id_rdata)
    );

    mts_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl_reg),
        .a         (m_rdata_eff),
        .b         (inc_q_reg),
        .res_valid (mac_res_valid),
        .res_index (mac_res_index),
        .res_value (mac_res_value)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tid_next       = tid_reg;
        sptr_next      = sptr_reg;
        hit_next       = hit_reg;
        live_next      = live_reg;
        cmp_valid_next = 1'b0;
        cmp_addr_next  = cmp_addr_reg;
        step_next      = step_reg;
        cp_valid_next  = 1'b0;
        cp_elem_next   = cp_elem_reg;
        valid_next     = 1'b0;
        result_next    = result_reg;
        m_we           = 1'b0;
        m_waddr        = {dst_ptr, 4'd0};
        m_wdata        = m_rdata_eff;
        id_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == FUNC_BEGIN)
                    begin
                        count_next = ONE_C;
                    end
                    else if (item.elem_index == LAST_ELEM)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            // full stack: single overflow item
                            valid_next            = 1'b1;
                            result_next.out_index = '0;
                            result_next.out_value = '0;
                            result_next.reused    = 1'b0;
                            result_next.overflow  = 1'b1;
                            result_next.last_out  = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                            tid_next   = item.transform_id;
                            sptr_next  = top_ptr;
                            live_next  = 1'b1;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                // issue id reads from the top down
                if (live_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_addr_next  = sptr_reg;
                    if (sptr_reg == '0)
                    begin
                        live_next = 1'b0;
                    end
                    else
                    begin
                        sptr_next = PTR_W'(sptr_reg - 1'b1);
                    end
                end
                // compare the id read in the previous cycle
                if (cmp_valid_reg)
                begin
                    if (id_eff == tid_reg)
                    begin
                        hit_next       = cmp_addr_reg;
                        state_next     = ST_COPY;
                        step_next      = '0;
                        live_next      = 1'b1;
                        cmp_valid_next = 1'b0;
                    end
                    else if (cmp_addr_reg == '0)
                    begin
                        state_next     = ST_MULT;
                        step_next      = '0;
                        live_next      = 1'b1;
                        cmp_valid_next = 1'b0;
                    end
                end
            end

            ST_COPY:
            begin
                if (live_reg)
                begin
                    step_next     = step_reg + 6'd1;
                    cp_valid_next = 1'b1;
                    cp_elem_next  = step_reg[3:0];
                    if (step_reg[3:0] == LAST_ELEM)
                    begin
                        live_next = 1'b0;
                    end
                end
                if (cp_valid_reg)
                begin
                    m_we                  = 1'b1;
                    m_waddr               = {dst_ptr, cp_elem_reg};
                    m_wdata               = m_rdata_eff;
                    valid_next            = 1'b1;
                    result_next.out_index = cp_elem_reg;
                    result_next.out_value = m_rdata_eff;
                    result_next.reused    = 1'b1;
                    result_next.overflow  = 1'b0;
                    result_next.last_out  = (cp_elem_reg == LAST_ELEM);
                    if (cp_elem_reg == LAST_ELEM)
                    begin
                        id_we      = 1'b1;
                        count_next = count_reg + ONE_C;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_MULT:
            begin
                if (live_reg)
                begin
                    step_next = step_reg + 6'd1;
                    if (&step_reg)
                    begin
                        live_next = 1'b0;
                    end
                end
                if (mac_res_valid)
                begin
                    m_we                  = 1'b1;
                    m_waddr               = {dst_ptr, mac_res_index};
                    m_wdata               = mac_res_value;
                    valid_next            = 1'b1;
                    result_next.out_index = mac_res_index;
                    result_next.out_value = mac_res_value;
                    result_next.reused    = 1'b0;
                    result_next.overflow  = 1'b0;
                    result_next.last_out  = (mac_res_index == LAST_ELEM);
                    if (mac_res_index == LAST_ELEM)
                    begin
                        id_we      = 1'b1;
                        count_next = count_reg + ONE_C;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= ONE_C;
            live_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cp_valid_reg  <= 1'b0;
            mac_ctrl_reg  <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            live_reg      <= live_next;
            cmp_valid_reg <= cmp_valid_next;
            cp_valid_reg  <= cp_valid_next;
            mac_ctrl_reg  <= mac_ctrl_next;
            valid_reg     <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        tid_reg      <= tid_next;
        sptr_reg     <= sptr_next;
        hit_reg      <= hit_next;
        cmp_addr_reg <= cmp_addr_next;
        step_reg     <= step_next;
        cp_elem_reg  <= cp_elem_next;
        result_reg   <= result_next;
        // tags follow the matrix read so the identity override lines up
        m_zero_reg   <= (m_raddr[MADDR_W-1:4] == '0);
        m_elem_reg   <= m_raddr[3:0];
        // incoming element new[k*4+row], aligned with the matrix read
        inc_q_reg    <= inc_mat[{step_reg[1:0], step_reg[3:2]}];
        if (accept && item.func == FUNC_ELEM)
        begin
            inc_mat[item.elem_index] <= item.elem_value;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // stack never empty and never above its depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= ONE_C) && (count_reg <= DEPTH_C))
        else $error("stack count out of range");

    // an overflow item always ends its run
    a_overflow_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.overflow |-> result.last_out && !result.reused)
        else $error("overflow item not marked last");

    // a normal run ends on element 15
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.last_out && !result.overflow |-> result.out_index == LAST_ELEM)
        else $error("last item of run not at element 15");

    // a completing element on a stack with room starts the search
    a_start_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.func == FUNC_ELEM && item.elem_index == LAST_ELEM &&
        count_reg < DEPTH_C |=> busy)
        else $error("completing element did not start a run");
`endif

endmodule

`default_nettype wire

[bench/tb_model_transform_stack_4x4.sv]
// testbench for model_transform_stack_4x4: a directed table of items, then random scenes
// each result is compared against a behavioral stack copy kept here or typed values
// depends on mts_pkg and model_transform_stack_4x4 from hdl/

module tb_model_transform_stack_4x4
    import mts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int RANDOM_ITEMS = 320;
    // a product is an id search plus 64 multiply-accumulates, far below this
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [31:0] Q_ONE = 32'h1 << FRAC_BITS;
    localparam logic [31:0] Q_TWO = 32'h2 << FRAC_BITS;
    localparam longint      Q_MAX = 64'sd2147483647;
    localparam longint      Q_MIN = -64'sd2147483648;

    // sender idle percentage per third of the random part
    localparam int IDLE_PHASES [3] = '{0, 62, 34};

    // corner values for elements 0..14 of the first delivered matrix
    localparam logic [31:0] CORNER_VALS [15] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
        32'hFFFF_0000, 32'h0000_0001, 32'h7FFF_0000, 32'h8001_0000, 32'h0000_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_8000, 32'hFFFF_8000, 32'h1234_5678
    };

    // the single result of a completing element on a full stack
    localparam result_t FULL_RESULT = '{
        out_index: 4'd0, out_value: 32'sd0, reused: 1'b0, overflow: 1'b1, last_out: 1'b1
    };

    // how a directed row is checked: by the predictor or by values typed in here
    typedef enum logic [1:0] {CHK_PREDICT, CHK_ECHO, CHK_IDENTITY, CHK_FULL} chk_kind_t;

    typedef struct {
        item_t     it;
        int        reps;
        chk_kind_t chk;
        logic      reused;
    } step_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    valid;
    result_t result;

    // behavioral copy of the stack, held by this bench
    logic [31:0] frame_mats [STACK_DEPTH][16];
    logic [31:0] frame_ids [STACK_DEPTH];
    int          frame_count;
    logic [31:0] pending_elems [16];

    result_t     expected_results [$];
    step_row_t   directed_rows [$];
    // last value delivered per position, for rows that expect the delivered matrix back
    logic [31:0] echo_elems [16];

    int      idle_pct;
    int      items_sent;
    int      pushes_sent;
    int      results_checked;
    int      reuse_seen;
    int      full_seen;
    int      saturated;
    int      error_count;
    int      stall_cycles;
    result_t want;

    model_transform_stack_4x4 #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .valid  (valid),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // stack predictor
    // ------------------------------------------------------------------

    // arithmetic shift drops the fraction toward minus infinity, then clamp to 32 bits
    function automatic logic [31:0] saturate_q(input longint acc);
        longint scaled;
        scaled = acc >>> FRAC_BITS;
        if (scaled > Q_MAX)
        begin
            saturated++;
            return 32'h7FFF_FFFF;
        end
        if (scaled < Q_MIN)
        begin
            saturated++;
            return 32'h8000_0000;
        end
        return scaled[31:0];
    endfunction

    // one identity entry tagged with id 0
    function automatic void clear_frames();
        int e;
        frame_count  = 1;
        frame_ids[0] = '0;
        for (e = 0; e < 16; e++)
        begin
            frame_mats[0][e] = (e % 5 == 0) ? Q_ONE : 32'h0;
        end
    endfunction

    // append one result to the expected queue
    function automatic void queue_result(input result_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic result_t element_result(input int e, input logic [31:0] value,
                                               input logic reused);
        result_t r;
        r.out_index = 4'(e);
        r.out_value = value;
        r.reused    = reused;
        r.overflow  = 1'b0;
        r.last_out  = (e == 15);
        return r;
    endfunction

    // advance the stack copy by one accepted item; queue its results when asked
    function automatic void predict_stack_step(input item_t it, input bit record);
        int          top, hit, col, row, k, e;
        bit          found;
        longint      acc;
        logic [31:0] fresh [16];
        if (it.func == FUNC_BEGIN)
        begin
            clear_frames();
            return;
        end
        pending_elems[it.elem_index] = it.elem_value;
        if (it.elem_index != LAST_ELEM)
            return;
        if (frame_count >= STACK_DEPTH)
        begin
            if (record)
                queue_result(FULL_RESULT);
            return;
        end
        top   = frame_count - 1;
        found = 1'b0;
        hit   = 0;
        // search from the top down, first match wins
        for (e = frame_count; e > 0; e--)
        begin
            if (!found && frame_ids[e - 1] == it.transform_id)
            begin
                found = 1'b1;
                hit   = e - 1;
            end
        end
        if (found)
        begin
            for (e = 0; e < 16; e++)
                fresh[e] = frame_mats[hit][e];
        end
        else
        begin
            // new * top, column-major, 64-bit wrapping sum of four exact products
            for (col = 0; col < 4; col++)
            begin
                for (row = 0; row < 4; row++)
                begin
                    acc = 0;
                    for (k = 0; k < 4; k++)
                        acc += longint'($signed(pending_elems[k * 4 + row]))
                             * longint'($signed(frame_mats[top][col * 4 + k]));
                    fresh[col * 4 + row] = saturate_q(acc);
                end
            end
        end
        for (e = 0; e < 16; e++)
            frame_mats[frame_count][e] = fresh[e];
        frame_ids[frame_count] = found ? frame_ids[hit] : it.transform_id;
        frame_count++;
        pushes_sent++;
        if (record)
        begin
            for (e = 0; e < 16; e++)
                queue_result(element_result(e, fresh[e], found));
        end
    endfunction

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------

    function automatic void add_row(input logic func, input int idx, input logic [31:0] value,
                                    input logic [31:0] id, input int reps,
                                    input chk_kind_t chk, input logic reused);
        step_row_t row;
        row.it.func         = func;
        row.it.elem_index   = 4'(idx);
        row.it.elem_value   = value;
        row.it.transform_id = id;
        row.reps            = reps;
        row.chk             = chk;
        row.reused          = reused;
        directed_rows       = {directed_rows, row};
    endfunction

    // results that can be written down directly: echo of the delivered matrix,
    // the identity entry, or the full-stack refusal
    function automatic void expect_typed(input step_row_t row);
        int e;
        if (row.chk == CHK_FULL)
        begin
            queue_result(FULL_RESULT);
            return;
        end
        for (e = 0; e < 16; e++)
        begin
            queue_result(element_result(e,
                (row.chk == CHK_IDENTITY) ? ((e % 5 == 0) ? Q_ONE : 32'h0) : echo_elems[e],
                row.reused));
        end
    endfunction

    // ------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------

    // mostly small values of magnitude up to two so products stay in range, some wide and corner ones
    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(9))
            0:       return CORNER_VALS[$urandom_range(14)];
            1, 2:    return $urandom;
            default: return 32'($urandom_range(262143)) - 32'd131072;
        endcase
    endfunction

    // half the ids come from a small pool so searches hit often, including the bottom entry's id 0
    function automatic logic [31:0] pick_id();
        unique case ($urandom_range(7))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'h100 + 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // drive one item, wait for the handshake, then update the predictor
    task automatic send_item(input item_t it, input bit record);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        predict_stack_step(it, record);
    endtask

    // one transform: full delivery, a few stray elements, or element 15 alone
    task automatic send_push();
        item_t it;
        int    kind, e;
        kind    = $urandom_range(19);
        it.func = FUNC_ELEM;
        if (kind < 7)
        begin
            for (e = 0; e < 15; e++)
            begin
                it.elem_index   = 4'(e);
                it.elem_value   = pick_value();
                it.transform_id = $urandom;
                send_item(it, 1'b1);
            end
        end
        else if (kind < 12)
        begin
            repeat ($urandom_range(1, 6))
            begin
                it.elem_index   = 4'($urandom_range(14));
                it.elem_value   = pick_value();
                it.transform_id = $urandom;
                send_item(it, 1'b1);
            end
        end
        it.elem_index   = LAST_ELEM;
        it.elem_value   = pick_value();
        it.transform_id = pick_id();
        send_item(it, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // result checker: strobed results cannot be held off, compare in order
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                          input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing expected, expected none, actual %p",
                         $realtime, result);
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("out_index", want.out_index, result.out_index);
                compare_field("out_value", want.out_value, result.out_value);
                compare_field("reused", want.reused, result.reused);
                compare_field("overflow", want.overflow, result.overflow);
                compare_field("last_out", want.last_out, result.last_out);
                results_checked++;
                if (result.last_out && result.reused)
                    reuse_seen++;
                if (result.overflow)
                    full_seen++;
            end
        end
    end

    // watchdog: ends the run when neither an item nor a result moves for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no item or result for %0d cycles", $realtime, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int    random_start;
        int    i, e;
        item_t it;

        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        idle_pct = 0;
        clear_frames();
        for (e = 0; e < 16; e++)
        begin
            pending_elems[e] = '0;
            echo_elems[e]    = '0;
        end

        // begin item on the reset stack, other fields are don't-care
        add_row(FUNC_BEGIN, 9, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1, CHK_PREDICT, 1'b0);
        // every position written before the first completing element
        for (e = 0; e < 15; e++)
            add_row(FUNC_ELEM, e, CORNER_VALS[e], (e % 2) ? 32'hFFFF_FFFF : 32'h0,
                    1, CHK_PREDICT, 1'b0);
        // new id on an identity top: the corner matrix comes back unchanged
        add_row(FUNC_ELEM, 15, Q_TWO, 32'hFFFF_FFFF, 1, CHK_ECHO, 1'b0);
        // corner matrix times itself, saturates both ways
        add_row(FUNC_ELEM, 15, Q_TWO, 32'h5A5A_5A5A, 1, CHK_PREDICT, 1'b0);
        // id found below the top entry is duplicated
        add_row(FUNC_ELEM, 15, Q_TWO, 32'hFFFF_FFFF, 1, CHK_ECHO, 1'b1);
        // id 0 hits the bottom identity entry; repeated until the stack is full
        add_row(FUNC_ELEM, 15, Q_TWO, 32'h0, 12, CHK_IDENTITY, 1'b1);
        // full stack refuses the push
        add_row(FUNC_ELEM, 15, Q_TWO, 32'h7, 1, CHK_FULL, 1'b0);
        // begin clears the stack but keeps the delivered elements
        add_row(FUNC_BEGIN, 0, 32'h0, 32'h0, 1, CHK_PREDICT, 1'b0);
        add_row(FUNC_ELEM, 15, Q_TWO, 32'h7, 1, CHK_ECHO, 1'b0);

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 34;
        for (i = 0; i < directed_rows.size(); i++)
        begin
            repeat (directed_rows[i].reps)
            begin
                if (directed_rows[i].it.func == FUNC_ELEM)
                    echo_elems[directed_rows[i].it.elem_index] = directed_rows[i].it.elem_value;
                send_item(directed_rows[i].it, directed_rows[i].chk == CHK_PREDICT);
                if (directed_rows[i].chk != CHK_PREDICT)
                    expect_typed(directed_rows[i]);
            end
        end

        // random scenes: usually a begin, then a run of transforms, sometimes
        // deep enough to fill the stack
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            idle_pct = IDLE_PHASES[((items_sent - random_start) * 3) / RANDOM_ITEMS];
            if ($urandom_range(3) != 0)
            begin
                it.func         = FUNC_BEGIN;
                it.elem_index   = 4'($urandom_range(15));
                it.elem_value   = $urandom;
                it.transform_id = $urandom;
                send_item(it, 1'b1);
            end
            repeat (($urandom_range(3) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 5))
            begin
                if (items_sent - random_start >= RANDOM_ITEMS)
                    break;
                send_push();
            end
        end
        start <= 1'b0;

        // drain: wait for every expected result, then watch for strays
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d items, %0d stack pushes and %0d checked results",
                 items_sent, pushes_sent, results_checked);
        $display("%0d duplicated entries, %0d full-stack refusals, %0d saturated elements",
                 reuse_seen, full_seen, saturated);
        if (error_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[model_transform_stack_4x4.f]
hdl/mts_pkg.sv
hdl/mts_ram.sv
hdl/mts_mac.sv
hdl/model_transform_stack_4x4.sv
bench/tb_model_transform_stack_4x4.sv
